// File: rtl/floor_match_and_remove_top_defines.svh
// Assertion macros for the floor match and remove block
`ifndef FLOOR_MATCH_AND_REMOVE_TOP_DEFINES_SVH
`define FLOOR_MATCH_AND_REMOVE_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define FMR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fmr check failed");

// next-cycle implication, sampled on clk, off during reset
`define FMR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fmr check failed");

`endif

// File: rtl/fmr_pkg.sv
// Shared types, codes and sizing functions for the floor match and remove block
`timescale 1ns / 1ps
package fmr_pkg;

  localparam int VALUE_W      = 32;
  localparam int STATUS_W     = 2;
  localparam int CAPACITY_DEF = 256;
  localparam int GROUP_LOG    = 4;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_CLAIM  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [VALUE_W-1:0] val;
    logic               vld;
    logic               le;
  } fmr_link_t;

  typedef struct packed {
    logic               ins_en;
    logic               clm_en;
    logic [VALUE_W-1:0] key;
  } fmr_ctl_t;

  localparam fmr_link_t LINK_HEAD = '{val: '0, vld: 1'b1, le: 1'b1};
  localparam fmr_link_t LINK_TAIL = '{val: '0, vld: 1'b0, le: 1'b0};

  function automatic int tree_log(input int cap);
    return (cap <= 2) ? 1 : $clog2(cap);
  endfunction

  function automatic int tree_lat(input int cap);
    int lg;
    lg = tree_log(cap);
    return (lg / GROUP_LOG) + (((lg % GROUP_LOG) != 0) ? 1 : 0);
  endfunction

endpackage

// File: rtl/fmr_cell.sv
// One storage cell of the sorted chain: compare, shift right on insert, left on claim
`timescale 1ns / 1ps
module fmr_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fmr_pkg::fmr_ctl_t                 ctl,
  input  fmr_pkg::fmr_link_t                lft,
  input  fmr_pkg::fmr_link_t                rgt,
  output fmr_pkg::fmr_link_t                lnk,
  output logic [fmr_pkg::VALUE_W-1:0]       leaf
);
  import fmr_pkg::*;

  logic [VALUE_W-1:0] val_r;
  logic [VALUE_W-1:0] val_nxt;
  logic               vld_r;
  logic               vld_nxt;
  logic               le;
  logic               match;

  assign le    = vld_r && (val_r <= ctl.key);
  assign match = le && !rgt.le;

  assign lnk.val = val_r;
  assign lnk.vld = vld_r;
  assign lnk.le  = le;
  assign leaf    = match ? val_r : '0;

  always_comb begin
    val_nxt = val_r;
    vld_nxt = vld_r;
    if (ctl.ins_en && !le) begin
      if (lft.le) begin
        val_nxt = ctl.key;
        vld_nxt = 1'b1;
      end else begin
        val_nxt = lft.val;
        vld_nxt = lft.vld;
      end
    end else if (ctl.clm_en && !(le && rgt.le)) begin
      val_nxt = rgt.val;
      vld_nxt = rgt.vld;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

endmodule

// File: rtl/fmr_or_tree.sv
// Registered OR-reduction tree that collects the one matching cell value
`timescale 1ns / 1ps
module fmr_or_tree #(
  parameter int N = fmr_pkg::CAPACITY_DEF,
  parameter int W = fmr_pkg::VALUE_W
) (
  input  logic         clk,
  input  logic [W-1:0] leaf [N],
  output logic [W-1:0] root
);
  import fmr_pkg::*;

  localparam int LOG    = tree_log(N);
  localparam int LEAVES = 1 << LOG;

  logic [W-1:0] node_q [1:2*LEAVES-1];

  for (genvar l = 0; l < LEAVES; l++) begin : g_leaf
    if (l < N) begin : g_used
      assign node_q[LEAVES+l] = leaf[l];
    end else begin : g_pad
      assign node_q[LEAVES+l] = '0;
    end
  end

  for (genvar n = 1; n < LEAVES; n++) begin : g_node
    localparam int DEPTH = $clog2(n + 1) - 1;
    logic [W-1:0] or_c;
    assign or_c = node_q[2*n] | node_q[2*n+1];
    if ((DEPTH == 0) || (((LOG - DEPTH) % GROUP_LOG) == 0)) begin : g_reg
      logic [W-1:0] or_r;
      always_ff @(posedge clk) begin
        or_r <= or_c;
      end
      assign node_q[n] = or_r;
    end else begin : g_comb
      assign node_q[n] = or_c;
    end
  end

  assign root = node_q[1];

endmodule

// File: rtl/floor_match_and_remove_top.sv
// Top level of the floor match and remove block: cell chain, match tree, handshakes
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | in_opcode, in_value
//   out_    | output    | out_valid/out_stall| out_status, out_matched_value
//
// An insert completes once the result register is free; a claim first waits
// out the register stages of the match OR tree (one stage per four tree levels).
// The input is stalled while a transaction is in flight.
// Synchronous active-low reset empties the store.
// A held result parks the block at the end of its transaction until taken.
`timescale 1ns / 1ps
module floor_match_and_remove_top #(
  parameter int CAPACITY = fmr_pkg::CAPACITY_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_opcode,
  input  logic [fmr_pkg::VALUE_W-1:0]      in_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [fmr_pkg::STATUS_W-1:0]     out_status,
  output logic [fmr_pkg::VALUE_W-1:0]      out_matched_value
);
  import fmr_pkg::*;

  localparam int TREE_LAT = tree_lat(CAPACITY);
  localparam int CNT_W    = $clog2(TREE_LAT + 1);

  logic                busy_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                op_r;
  logic [VALUE_W-1:0]  key_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [VALUE_W-1:0]  out_value_r;

  fmr_link_t          lnk  [CAPACITY];
  logic [VALUE_W-1:0] leaf [CAPACITY];
  logic [VALUE_W-1:0] root;
  fmr_ctl_t           ctl;

  logic in_acc;
  logic ready_done;
  logic done;
  logic full;
  logic found;

  assign in_stall = busy_r;
  assign in_acc   = in_valid && !busy_r;
  assign full     = lnk[CAPACITY-1].vld;
  assign found    = lnk[0].le;

  assign ready_done = (op_r == OP_INSERT) || (cnt_r == CNT_W'(TREE_LAT));
  assign done       = busy_r && ready_done && (!out_valid_r || !out_stall);

  assign ctl.ins_en = done && (op_r == OP_INSERT) && !full;
  assign ctl.clm_en = done && (op_r == OP_CLAIM) && found;
  assign ctl.key    = key_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    fmr_link_t lft_s;
    fmr_link_t rgt_s;
    if (i == 0) begin : g_head
      assign lft_s = LINK_HEAD;
    end else begin : g_mid_l
      assign lft_s = lnk[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign rgt_s = LINK_TAIL;
    end else begin : g_mid_r
      assign rgt_s = lnk[i+1];
    end
    fmr_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .ctl  (ctl),
      .lft  (lft_s),
      .rgt  (rgt_s),
      .lnk  (lnk[i]),
      .leaf (leaf[i])
    );
  end

  fmr_or_tree #(
    .N(CAPACITY),
    .W(VALUE_W)
  ) u_tree (
    .clk (clk),
    .leaf(leaf),
    .root(root)
  );

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_opcode;
      key_r <= in_value;
    end
    if (done) begin
      if (op_r == OP_INSERT) begin
        out_status_r <= full ? ST_FULL : ST_INSERTED;
        out_value_r  <= '0;
      end else begin
        out_status_r <= found ? ST_FOUND : ST_NONE;
        out_value_r  <= found ? root : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (done) begin
        busy_r <= 1'b0;
      end else if (busy_r && (cnt_r != CNT_W'(TREE_LAT))) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_matched_value = out_value_r;

endmodule

// File: rtl/fmr_chk.sv
// Port-level checker for the floor match and remove block, with its bind
`timescale 1ns / 1ps
`include "floor_match_and_remove_top_defines.svh"
module fmr_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [fmr_pkg::STATUS_W-1:0]     out_status,
  input logic [fmr_pkg::VALUE_W-1:0]      out_matched_value
);
  import fmr_pkg::*;

  `FMR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `FMR_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_status) && $stable(out_matched_value))
  `FMR_ASSERT_NEXT(a_busy_after_acc, in_valid && !in_stall, in_stall)
  `FMR_ASSERT_NOW(a_result_frees_in, $rose(out_valid), !in_stall)
  `FMR_ASSERT_NOW(a_zero_unless_found, out_valid && (out_status != ST_FOUND), out_matched_value == '0)

endmodule

bind floor_match_and_remove_top fmr_chk u_chk (.*);
